[rtl/core/lmtf_pkg.sv]
// ----------------------------------------------------------------------------
// lmtf_pkg
// Shared constants, types and command codes for the recency stack core.
// ----------------------------------------------------------------------------
`default_nettype none

package lmtf_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 16;
    localparam int FILL_W = 5;
    localparam int CMD_W  = 2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [CMD_W-1:0]  cmd_t;

    localparam cmd_t CMD_PUSH   = 2'd0;
    localparam cmd_t CMD_POP    = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;

    typedef struct packed {
        cmd_t  command;
        data_t value;
    } req_t;

    typedef struct packed {
        data_t popped_value;
        logic  found;
        logic  empty_error;
        logic  dropped;
        fill_t fill_count;
    } rsp_t;

    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        data_t wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

[rtl/core/lmtf_ram.sv]
// ----------------------------------------------------------------------------
// lmtf_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/lmtf_ctrl.sv]
// ----------------------------------------------------------------------------
// lmtf_ctrl
// Sequencer: searches, shifts and updates the stack held in memory.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire lmtf_pkg::req_t      req,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output lmtf_pkg::rsp_t           res,
    output lmtf_pkg::mem_req_t       mem,
    input  wire lmtf_pkg::data_t     rd_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg,    state_next;
    lmtf_pkg::cnt_t    count_reg,    count_next;
    lmtf_pkg::cmd_t    cmd_reg,      cmd_next;
    lmtf_pkg::data_t   value_reg,    value_next;
    lmtf_pkg::cnt_t    idx_reg,      idx_next;
    logic              cmp_vld_reg,  cmp_vld_next;
    lmtf_pkg::cnt_t    cmp_idx_reg,  cmp_idx_next;
    logic              pend_reg,     pend_next;
    lmtf_pkg::addr_t   pend_addr_reg, pend_addr_next;
    lmtf_pkg::rsp_t    res_reg,      res_next;

    logic              rd_ok;
    lmtf_pkg::cnt_t    top_idx;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign rd_ok     = (idx_reg < count_reg);
    assign top_idx   = count_reg - lmtf_pkg::cnt_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        res_next       = res_reg;
        mem            = '0;

        case (state_reg)
            S_IDLE:
            begin
                // pop read issued speculatively
                mem.rd_en   = 1'b1;
                mem.rd_addr = top_idx[lmtf_pkg::ADDR_W-1:0];
                if (req_valid)
                begin
                    cmd_next            = req.command;
                    value_next          = req.value;
                    idx_next            = '0;
                    res_next            = '0;
                    res_next.fill_count = lmtf_pkg::fill_t'(count_reg);
                    case (req.command)
                        lmtf_pkg::CMD_PUSH, lmtf_pkg::CMD_LOOKUP:
                        begin
                            state_next = S_SEARCH;
                        end
                        lmtf_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.empty_error = 1'b1;
                                state_next           = S_DONE;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                res_next.popped_value = rd_data;
                count_next            = top_idx;
                res_next.fill_count   = lmtf_pkg::fill_t'(top_idx);
                state_next            = S_DONE;
            end

            S_SEARCH:
            begin
                mem.rd_en    = rd_ok;
                mem.rd_addr  = idx_reg[lmtf_pkg::ADDR_W-1:0];
                cmp_vld_next = rd_ok;
                cmp_idx_next = idx_reg;
                if (rd_ok)
                begin
                    idx_next = idx_reg + lmtf_pkg::cnt_t'(1);
                end
                if (cmp_vld_reg && (rd_data == value_reg))
                begin
                    res_next.found = 1'b1;
                    cmp_vld_next   = 1'b0;
                    if (cmd_reg == lmtf_pkg::CMD_PUSH)
                    begin
                        idx_next   = cmp_idx_reg + lmtf_pkg::cnt_t'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!rd_ok && !cmp_vld_reg)
                begin
                    // value absent
                    if (cmd_reg == lmtf_pkg::CMD_PUSH)
                    begin
                        if (count_reg < lmtf_pkg::cnt_t'(lmtf_pkg::DEPTH))
                        begin
                            mem.wr_en           = 1'b1;
                            mem.wr_addr         = count_reg[lmtf_pkg::ADDR_W-1:0];
                            mem.wr_data         = value_reg;
                            count_next          = count_reg + lmtf_pkg::cnt_t'(1);
                            res_next.fill_count =
                                lmtf_pkg::fill_t'(count_reg + lmtf_pkg::cnt_t'(1));
                        end
                        else
                        begin
                            res_next.dropped = 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                mem.rd_en   = rd_ok;
                mem.rd_addr = idx_reg[lmtf_pkg::ADDR_W-1:0];
                if (rd_ok)
                begin
                    idx_next       = idx_reg + lmtf_pkg::cnt_t'(1);
                    pend_next      = 1'b1;
                    pend_addr_next =
                        lmtf_pkg::addr_t'(idx_reg - lmtf_pkg::cnt_t'(1));
                end
                if (pend_reg)
                begin
                    // close up the gap
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = pend_addr_reg;
                    mem.wr_data = rd_data;
                end
                else if (!rd_ok)
                begin
                    // moved value goes on top
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = top_idx[lmtf_pkg::ADDR_W-1:0];
                    mem.wr_data = value_reg;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        value_reg     <= value_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

[rtl/core/lru_move_to_front_stack_core.sv]
// ----------------------------------------------------------------------------
// lru_move_to_front_stack_core
// Recency stack of 16-bit block numbers with push, pop and lookup.
//
// Request channel (req_valid/req_ready/req) carries a command and a value;
// response channel (rsp_valid/rsp_ready/rsp) returns one result per request.
// A push moves the value to the top (or drops it when the stack is full and
// the value is absent), a pop removes the top, a lookup reports presence.
// Entries sit in a 16-entry memory with one write and one registered read
// port; a search reads one entry a cycle, and closing up the gap after a
// push of a present value moves one entry a cycle through that memory.
// An unused command code only reports the fill count. One request is
// worked on at a time; the next request is taken as soon as the sequencer
// is free, even while a response still sits in the output register.
// Reset empties the stack at once; memory contents are not cleared.
// While the receiver stalls, the response holds in the output register and
// a finished result waits in the sequencer until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_move_to_front_stack_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire lmtf_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output lmtf_pkg::rsp_t       rsp
);

    lmtf_pkg::mem_req_t  mem;
    lmtf_pkg::data_t     rd_data;
    logic                res_valid;
    logic                res_ready;
    lmtf_pkg::rsp_t      res;
    logic                rsp_valid_reg;
    lmtf_pkg::rsp_t      rsp_reg;

    lmtf_ram #(
        .WIDTH (lmtf_pkg::DATA_W),
        .DEPTH (lmtf_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

    lmtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem       (mem),
        .rd_data   (rd_data)
    );

    // output register
    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

endmodule

`default_nettype wire

[tb/tb_lru_move_to_front_stack_core.sv]
// ----------------------------------------------------------------------------
// tb_lru_move_to_front_stack_core
// Self-checking bench for the recency stack core.
//
// A short table of directed requests covers the empty stack, the full stack,
// the extreme block numbers, every command and the unused command code. Rows
// with an obvious answer carry it. All other rows are checked against a
// shadow copy of the stack. A random phase follows, with varying push weight
// so that the stack runs empty and full many times. Block numbers come mostly
// from a small pool so that pushes and lookups hit often. Both channels
// idle at random, except for one quiet stretch. A watchdog ends the run if
// transfers stop.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_move_to_front_stack_core;

    import lmtf_pkg::*;

    localparam cmd_t CMD_UNUSED   = 2'd3;
    localparam int   IDLE_PCT     = 13;
    localparam int   RANDOM_ITEMS = 924;
    localparam int   STALL_LIMIT  = 3000;
    localparam int   DRAIN_CYCLES = 48;
    localparam int   POOL_SIZE    = 20;
    localparam int   N_ROWS       = 26;

    typedef struct packed {
        cmd_t  command;
        data_t value;
        logic  typed;
        rsp_t  want;
    } stim_row_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // side data that travels with the request being offered
    logic drv_typed = 1'b0;
    rsp_t drv_want  = '0;
    bit   quiet     = 1'b0;

    data_t       shadow_stack [DEPTH];
    int          shadow_fill;
    rsp_t        pending_results [$];
    data_t       value_pool [POOL_SIZE];
    int unsigned errors;
    int unsigned stall_cycles;
    int unsigned n_cmd [4];
    int unsigned n_hit, n_dropped, n_empty, n_checked;

    stim_row_t directed_rows [N_ROWS] = '{
        '{CMD_POP,    16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 5'd0}},
        '{CMD_LOOKUP, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0, 5'd0}},
        '{CMD_UNUSED, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0, 5'd0}},
        '{CMD_PUSH,   16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0, 5'd1}},
        '{CMD_PUSH,   16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0, 5'd2}},
        '{CMD_PUSH,   16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 5'd2}},
        '{CMD_POP,    16'hBEEF, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 1'b0, 5'd1}},
        '{CMD_PUSH,   16'h8000, 1'b0, '0},
        '{CMD_PUSH,   16'h0001, 1'b0, '0},
        '{CMD_PUSH,   16'h5555, 1'b0, '0},
        '{CMD_PUSH,   16'hAAAA, 1'b0, '0},
        '{CMD_PUSH,   16'h00FF, 1'b0, '0},
        '{CMD_PUSH,   16'hFF00, 1'b0, '0},
        '{CMD_PUSH,   16'h0F0F, 1'b0, '0},
        '{CMD_PUSH,   16'hF0F0, 1'b0, '0},
        '{CMD_PUSH,   16'h1234, 1'b0, '0},
        '{CMD_PUSH,   16'h4321, 1'b0, '0},
        '{CMD_PUSH,   16'h7FFF, 1'b0, '0},
        '{CMD_PUSH,   16'hFFFE, 1'b0, '0},
        '{CMD_PUSH,   16'h0002, 1'b0, '0},
        '{CMD_PUSH,   16'h4000, 1'b0, '0},
        '{CMD_PUSH,   16'hFFFF, 1'b0, '0},
        '{CMD_PUSH,   16'h2468, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1, 5'd16}},
        '{CMD_PUSH,   16'h0000, 1'b0, '0},
        '{CMD_PUSH,   16'h1234, 1'b0, '0},
        '{CMD_LOOKUP, 16'h2468, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0, 5'd16}}
    };

    lru_move_to_front_stack_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // shadow stack, bottom at index 0, updates on every accepted request
    function automatic rsp_t apply_command(req_t r);
        rsp_t o;
        int   pos;
        o   = '0;
        pos = -1;
        case (r.command)
            CMD_PUSH:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (pos < 0 && shadow_stack[i] == r.value)
                        pos = i;
                if (pos >= 0)
                begin
                    o.found = 1'b1;
                    for (int j = pos; j < shadow_fill - 1; j++)
                        shadow_stack[j] = shadow_stack[j + 1];
                    shadow_fill--;
                end
                if (shadow_fill < DEPTH)
                begin
                    shadow_stack[shadow_fill] = r.value;
                    shadow_fill++;
                end
                else
                    o.dropped = 1'b1;
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    o.empty_error = 1'b1;
                else
                begin
                    shadow_fill--;
                    o.popped_value = shadow_stack[shadow_fill];
                end
            end
            CMD_LOOKUP:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_stack[i] == r.value)
                        o.found = 1'b1;
            end
            default: ;
        endcase
        o.fill_count = fill_t'(shadow_fill);
        return o;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        errors++;
        $display("rsp %s wrong: got %0h, want %0h (response %0d)", field, got, want,
                 n_checked);
    endtask

    task automatic compare_result(rsp_t got, rsp_t want);
        if (got.popped_value !== want.popped_value)
            report_mismatch("popped_value", got.popped_value, want.popped_value);
        if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
        if (got.empty_error !== want.empty_error)
            report_mismatch("empty_error", got.empty_error, want.empty_error);
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
        if (got.fill_count !== want.fill_count)
            report_mismatch("fill_count", got.fill_count, want.fill_count);
    endtask

    // response check, request capture and watchdog, all on the rising edge
    always @(posedge clk)
    begin
        rsp_t predicted;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("with nothing outstanding", rsp, 0);
                else
                    compare_result(rsp, pending_results.pop_front());
                n_checked++;
            end
            if (req_valid && req_ready)
            begin
                predicted = apply_command(req);
                n_cmd[req.command]++;
                if (predicted.found && req.command == CMD_PUSH)
                    n_hit++;
                if (predicted.dropped)
                    n_dropped++;
                if (predicted.empty_error)
                    n_empty++;
                pending_results.push_back(drv_typed ? drv_want : predicted);
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: no transfer for %0d cycles, %0d outstanding",
                             stall_cycles, pending_results.size());
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(req_t r, logic typed, rsp_t want);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        drv_typed <= typed;
        drv_want  <= want;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic data_t pick_value();
        if ($urandom_range(0, 99) < 75)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return data_t'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        req_t        r;
        int          push_w;
        int          roll;
        int unsigned n_real;
        errors       = 0;
        stall_cycles = 0;
        shadow_fill  = 0;
        n_hit        = 0;
        n_dropped    = 0;
        n_empty      = 0;
        n_checked    = 0;
        foreach (n_cmd[k])
            n_cmd[k] = 0;
        value_pool[0] = 16'h0000;
        value_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_SIZE; k++)
            value_pool[k] = data_t'($urandom_range(0, 65535));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            r.command = directed_rows[i].command;
            r.value   = directed_rows[i].value;
            send(r, directed_rows[i].typed, directed_rows[i].want);
        end

        n_real = 0;
        push_w = 50;
        while (n_real < RANDOM_ITEMS)
        begin
            if (n_real % 120 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: push_w = 25;
                    1: push_w = 45;
                    2: push_w = 65;
                    default: push_w = 85;
                endcase
            end
            quiet = (n_real >= 400 && n_real < 600);
            roll  = $urandom_range(0, 99);
            if (roll < 3)
                r.command = CMD_UNUSED;
            else if (roll < 3 + push_w)
                r.command = CMD_PUSH;
            else if (roll < 3 + push_w + (97 - push_w) / 2)
                r.command = CMD_POP;
            else
                r.command = CMD_LOOKUP;
            r.value = pick_value();
            send(r, 1'b0, '0);
            if (r.command != CMD_UNUSED)
                n_real++;
        end
        req_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d push, %0d pop, %0d lookup, %0d unused code",
                 n_cmd[0] + n_cmd[1] + n_cmd[2] + n_cmd[3],
                 n_cmd[CMD_PUSH], n_cmd[CMD_POP], n_cmd[CMD_LOOKUP], n_cmd[CMD_UNUSED]);
        $display("%0d pushes moved a present value, %0d dropped at full, %0d pops on empty",
                 n_hit, n_dropped, n_empty);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
